// ===== sv/fnh_pkg.sv =====
// package for the float numeric hash block
// holds field widths, register indexes and small shared types; no dependencies
package fnh_pkg;

   localparam int VALUE_WIDTH = 64;
   localparam int HASH_WIDTH  = 64;
   localparam int EXP_WIDTH   = 11;
   localparam int FRAC_WIDTH  = 52;
   localparam int MANT_WIDTH  = 53;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NAN_HASH = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INF_HASH = 1'b1;

   localparam logic [HASH_WIDTH-1:0] INF_HASH_RESET = 64'd314159;
   localparam logic [EXP_WIDTH-1:0]  EXP_ALL_ONES   = '1;

   // item class decided in the first stage
   typedef enum logic [1:0] {
      KIND_NUM  = 2'd0,
      KIND_ZERO = 2'd1,
      KIND_NAN  = 2'd2,
      KIND_INF  = 2'd3
   } kind_type;

   typedef logic [HASH_WIDTH-1:0] hash_type;

endpackage

// ===== sv/fnh_if.sv =====
// valid/ready channel interface used by the req and rsp ports of the float numeric hash
// generic payload width; no package dependency
interface fnh_if #(
   parameter int WIDTH = 64
) (
   input logic clock
);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/fnh_csr_if.sv =====
// configuration write channel: register index and write data
// uses fnh_pkg for widths
interface fnh_csr_if (
   input logic clock
);
   logic                                valid;
   logic                                ready;
   logic [fnh_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [fnh_pkg::HASH_WIDTH-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/fnh_regs.sv =====
// configuration registers nan_hash and inf_hash
// uses fnh_pkg and fnh_csr_if
module fnh_regs (
   input  logic                clock,
   input  logic                reset,
   fnh_csr_if.sink             csr,
   output fnh_pkg::hash_type   nan_hash,
   output fnh_pkg::hash_type   inf_hash
);
   import fnh_pkg::*;

   hash_type nan_ff, inf_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         nan_ff <= '0;
         inf_ff <= INF_HASH_RESET;
      end else if (csr.valid) begin
         unique case (csr.index)
            CSR_NAN_HASH: nan_ff <= csr.data;
            CSR_INF_HASH: inf_ff <= csr.data;
            default: ;
         endcase
      end
   end

   assign nan_hash = nan_ff;
   assign inf_hash = inf_ff;
endmodule

// ===== sv/fnh_pipe.sv =====
// four-stage hash datapath: decode, reduce, rotate, negate/select
// uses fnh_pkg; stalls freeze all stages together, output holds in stage four
module fnh_pipe #(
   parameter int MODULUS_BITS = 61
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [63:0]       in_bits,
   input  fnh_pkg::hash_type nan_hash,
   input  fnh_pkg::hash_type inf_hash,
   output logic              out_valid,
   input  logic              out_ready,
   output fnh_pkg::hash_type out_hash
);
   import fnh_pkg::*;

   localparam int B = MODULUS_BITS;
   localparam int RW = $clog2(B);
   localparam logic [B-1:0] MOD_P = '1;
   // exponent offset chosen so (exp_eff + OFS) >= 0 and OFS == -1075 mod B
   localparam int OFS_RAW = ((1075 / B) + 1) * B - 1075;
   localparam logic [11:0] OFS = 12'(OFS_RAW);
   // reciprocal of B scaled by 2^24, rounded up; exact quotient for 12-bit inputs
   localparam int RK = 24;
   localparam logic [19:0] RECIP = 20'(((1 << RK) + B - 1) / B);

   logic advance;
   assign advance  = !out_valid || out_ready;
   assign in_ready = advance;

   // stage 1: decode
   logic          v1_ff;
   kind_type      k1_ff;
   logic          neg1_ff;
   logic [52:0]   m1_ff;
   logic [11:0]   ex1_ff;

   logic [10:0] exf;
   logic [51:0] frac;
   assign exf  = in_bits[62:52];
   assign frac = in_bits[51:0];

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (advance) v1_ff <= in_valid;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         neg1_ff <= in_bits[63];
         if (exf == EXP_ALL_ONES) k1_ff <= (frac != '0) ? KIND_NAN : KIND_INF;
         else if (exf == '0 && frac == '0) k1_ff <= KIND_ZERO;
         else k1_ff <= KIND_NUM;
         m1_ff <= {exf != '0, frac};
         // subnormals use exponent field 1
         ex1_ff <= {1'b0, (exf == '0) ? 11'd1 : exf} + OFS;
      end
   end

   // stage 2: m mod P (m < 2^53 so one fold suffices when B >= 53), e mod B
   logic          v2_ff;
   kind_type      k2_ff;
   logic          neg2_ff;
   logic [B-1:0]  r2_ff;
   logic [RW-1:0] rot2_ff;

   logic [63:0] m64, fold;
   logic [B-1:0] red;
   always_comb begin
      m64  = {11'd0, m1_ff};
      fold = (m64 & {{(64-B){1'b0}}, MOD_P}) + (m64 >> B);
      fold = (fold & {{(64-B){1'b0}}, MOD_P}) + (fold >> B);
      red  = fold[B-1:0];
      if (red == MOD_P) red = '0;
   end

   // exponent mod B by reciprocal multiply and one back-multiply
   logic [31:0] qprod;
   logic [6:0]  quot;
   logic [11:0] rem;
   always_comb begin
      qprod = {20'd0, ex1_ff} * {12'd0, RECIP};
      quot  = qprod[RK+6:RK];
      rem   = ex1_ff - ({5'd0, quot} * 12'(B));
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (advance) v2_ff <= v1_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         k2_ff   <= k1_ff;
         neg2_ff <= neg1_ff;
         r2_ff   <= red;
         rot2_ff <= rem[RW-1:0];
      end
   end

   // stage 3: rotate within B bits
   logic         v3_ff;
   kind_type     k3_ff;
   logic         neg3_ff;
   logic [B-1:0] h3_ff;

   logic [2*B-1:0] dbl;
   assign dbl = {r2_ff, r2_ff} << rot2_ff;

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (advance) v3_ff <= v2_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         k3_ff   <= k2_ff;
         neg3_ff <= neg2_ff;
         h3_ff   <= dbl[2*B-1:B];
      end
   end

   // stage 4: sign, all-ones fix and special values
   logic     v4_ff;
   hash_type h4_ff;
   hash_type hv, hn;
   always_comb begin
      hv = {{(64-B){1'b0}}, h3_ff};
      hn = neg3_ff ? (64'd0 - hv) : hv;
      if (hn == '1) hn = hn - 64'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (advance) v4_ff <= v3_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         case (k3_ff)
            KIND_NAN:  h4_ff <= nan_hash;
            KIND_INF:  h4_ff <= inf_hash;
            KIND_ZERO: h4_ff <= '0;
            default:   h4_ff <= hn;
         endcase
      end
   end

   assign out_valid = v4_ff;
   assign out_hash  = h4_ff;
endmodule

// ===== sv/float_numeric_hash.sv =====
// top level of the float numeric hash block
// uses fnh_pkg, fnh_if, fnh_csr_if, fnh_regs and fnh_pipe
//
//  channel   dir   payload              handshake
//  req       in    value_bits[63:0]     req.valid / req.ready
//  rsp       out   hash_value[63:0]     rsp.valid / rsp.ready
//  csr       in    index, data[63:0]    csr.valid / csr.ready (always ready)
//
// one word per cycle unless rsp stalls; each accepted req word yields one rsp word
// after passing the four register stages: decode, reduce, rotate, select
// rsp stall freezes the whole pipeline; req.ready follows the last stage
// synchronous reset clears valid bits and loads register reset values
module float_numeric_hash #(
   parameter int MODULUS_BITS = 61
) (
   input logic clock,
   input logic reset,
   fnh_if.sink     req,
   fnh_if.source   rsp,
   fnh_csr_if.sink csr
);
   import fnh_pkg::*;

   hash_type nan_hash, inf_hash;

   fnh_regs u_regs (
      .clock    (clock),
      .reset    (reset),
      .csr      (csr),
      .nan_hash (nan_hash),
      .inf_hash (inf_hash)
   );

   fnh_pipe #(.MODULUS_BITS(MODULUS_BITS)) u_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_bits   (req.data),
      .nan_hash  (nan_hash),
      .inf_hash  (inf_hash),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_hash  (rsp.data)
   );
endmodule
